@@ rtl/core/sobel_edge_magnitude_assert.svh @@
// Assertion macros for the Sobel edge magnitude block.
// Used by the port checker; no other dependencies.
`ifndef SOBEL_EDGE_MAGNITUDE_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_ASSERT_SVH
// assert that a implies b in the same cycle
`define SEM_ASSERT_IMP(label, clk, rstn, a, b) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("assertion failed");
// assert that a implies b in the next cycle
`define SEM_ASSERT_NXT(label, clk, rstn, a, b) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("assertion failed");
`endif

@@ rtl/core/sem_pkg.sv @@
// Shared types and constants for the Sobel edge magnitude block.
// No dependencies.
`timescale 1ns / 1ps
package sem_pkg;
  localparam int MAX_LINE = 1024;
  localparam logic [10:0] WIDTH_RESET = 11'd640;
  localparam logic [15:0] HEIGHT_RESET = 16'd480;
  localparam logic [0:0] CFG_WIDTH = 1'b0;
  localparam logic [0:0] CFG_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_SEND = 3'b100
  } state_e;

  typedef struct packed {
    logic load;   // take the accepted request into the window
    logic calc;   // run one step of the magnitude unit
    logic start;  // reset magnitude unit and register window sums
    logic push;   // move the finished result into the output register
  } cmd_t;

  typedef struct packed {
    logic emits;  // the loaded item produces a result
    logic done;   // magnitude unit finished
  } sts_t;
endpackage

@@ rtl/core/sem_ctrl.sv @@
// Controller state machine for the Sobel edge magnitude block.
// Depends on sem_pkg.
`timescale 1ns / 1ps
module sem_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  sem_pkg::sts_t sts_i,
  output sem_pkg::cmd_t cmd_o
);
  sem_pkg::state_e state_q, state_d;
  logic start_q, start_d;
  logic seed_q, seed_d;
  logic full_q, full_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sem_pkg::ST_IDLE;
      start_q <= 1'b0;
      seed_q <= 1'b0;
      full_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= start_d;
      seed_q <= seed_d;
      full_q <= full_d;
    end
  end

  assign out_valid_o = full_q;

  always_comb begin
    state_d = state_q;
    start_d = 1'b0;
    seed_d = start_q;
    full_d = full_q && !out_ready_i;
    in_ready_o = 1'b0;
    cmd_o = '0;
    unique case (state_q)
      sem_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = sem_pkg::ST_CALC;
          start_d = 1'b1;
        end
      end
      sem_pkg::ST_CALC: begin
        // window shifts in the cycle after load; decide and seed after it
        if (seed_q) begin
          cmd_o.start = 1'b1;
          if (!sts_i.emits) state_d = sem_pkg::ST_IDLE;
        end else if (!start_q) begin
          if (sts_i.done) begin
            if (!full_q || out_ready_i) begin
              cmd_o.push = 1'b1;
              full_d = 1'b1;
              state_d = sem_pkg::ST_IDLE;
            end else begin
              state_d = sem_pkg::ST_SEND;
            end
          end else begin
            cmd_o.calc = 1'b1;
          end
        end
      end
      sem_pkg::ST_SEND: begin
        // hold the result until the output register frees up
        if (!full_q || out_ready_i) begin
          cmd_o.push = 1'b1;
          full_d = 1'b1;
          state_d = sem_pkg::ST_IDLE;
        end
      end
      default: state_d = sem_pkg::ST_IDLE;
    endcase
  end
endmodule

@@ rtl/core/sem_datapath.sv @@
// Datapath: line buffers, 3x3 window, position counters, Sobel sums and
// a bit-serial square root per channel. Depends on sem_pkg.
`timescale 1ns / 1ps
module sem_datapath #(
  parameter int MaxLine = sem_pkg::MAX_LINE
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [0:0]    cfg_idx_i,
  input  logic [15:0]   cfg_data_i,
  input  logic          func_i,
  input  logic [23:0]   pix_i,
  input  sem_pkg::cmd_t cmd_i,
  output sem_pkg::sts_t sts_o,
  output logic [23:0]   edge_o,
  output logic          last_o
);
  localparam int AW = (MaxLine > 1) ? $clog2(MaxLine) : 1;
  localparam int CW = $clog2(MaxLine + 2);

  logic [10:0] fw_q;
  logic [15:0] fh_q;
  logic [CW-1:0] w;
  logic [15:0] h;
  always_comb begin
    if (fw_q == 11'd0) w = CW'(1);
    else if (32'(fw_q) > MaxLine) w = CW'(MaxLine);
    else w = CW'(fw_q);
    h = (fh_q == 16'd0) ? 16'd1 : fh_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= sem_pkg::WIDTH_RESET;
      fh_q <= sem_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == sem_pkg::CFG_WIDTH) fw_q <= cfg_data_i[10:0];
      else fh_q <= cfg_data_i;
    end
  end

  logic [23:0] mem_up [MaxLine];
  logic [23:0] mem_lo [MaxLine];
  logic [CW-1:0] in_col_q, out_col_q, seen_q;
  logic [15:0] in_row_q, out_row_q;
  logic [23:0] win_q [9];
  logic [23:0] v_q;
  logic emit_q;
  logic [CW-1:0] col;
  logic [23:0] v;
  assign col = (in_col_q >= w) ? '0 : in_col_q;
  assign v = func_i ? 24'd0 : pix_i;

  // read both rows on load; window shift completes on the next cycle
  logic [23:0] up_q, lo_q;
  logic [AW-1:0] addr;
  assign addr = col[AW-1:0];
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      up_q <= mem_up[addr];
      lo_q <= mem_lo[addr];
      mem_up[addr] <= mem_lo[addr];
      mem_lo[addr] <= v;
      v_q <= v;
    end
  end

  logic last;
  assign last = (out_col_q + CW'(1) >= w) && (32'(out_row_q) + 1 >= 32'(h));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0;
      in_row_q <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      seen_q <= '0;
      emit_q <= 1'b0;
    end else if (cmd_i.load) begin
      if (col + CW'(1) >= w) begin
        in_col_q <= '0;
        if (in_row_q != 16'hFFFF) in_row_q <= in_row_q + 16'd1;
      end else begin
        in_col_q <= col + CW'(1);
      end
      if (seen_q < w + CW'(1)) begin
        seen_q <= seen_q + CW'(1);
        emit_q <= 1'b0;
      end else begin
        emit_q <= 1'b1;
      end
    end else if (cmd_i.start && emit_q) begin
      // advance output position; frame end clears all counters
      if (last) begin
        in_col_q <= '0;
        in_row_q <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
        seen_q <= '0;
      end else if (out_col_q + CW'(1) >= w) begin
        out_col_q <= '0;
        out_row_q <= out_row_q + 16'd1;
      end else begin
        out_col_q <= out_col_q + CW'(1);
      end
    end
  end

  // window shift on the cycle after load
  logic shift_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) shift_q <= 1'b0;
    else shift_q <= cmd_i.load;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else if (shift_q) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k*3]   <= win_q[k*3+1];
        win_q[k*3+1] <= win_q[k*3+2];
      end
      win_q[2] <= up_q;
      win_q[5] <= lo_q;
      win_q[8] <= v_q;
    end
  end

  // tap mask for the current output position; a position past a shrunk
  // frame masks every tap beyond the new bounds
  logic [8:0] mask;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mask[i*3+j] = !((i == 0 && out_row_q == 16'd0) ||
                        (32'(out_row_q) + i >= 32'(h) + 1) ||
                        (j == 0 && out_col_q == '0) ||
                        (32'(out_col_q) + j >= 32'(w) + 1));
      end
    end
  end

  logic [16:0] s_q [3];
  logic [8:0]  q_q [3];
  logic [7:0]  bit_q;
  logic [7:0]  res [3];
  logic        last_q;
  logic [23:0] edge_q;
  logic        frame_end_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      last_q <= last;
      bit_q <= 8'd128;
      for (int c = 0; c < 3; c++) begin
        logic signed [11:0] gx, gy;
        logic [7:0] p [9];
        logic [10:0] ax, ay;
        for (int t = 0; t < 9; t++) p[t] = mask[t] ? win_q[t][c*8 +: 8] : 8'd0;
        gx = 12'(p[2]) + 12'(p[8]) + (12'(p[5]) <<< 1)
           - 12'(p[0]) - 12'(p[6]) - (12'(p[3]) <<< 1);
        gy = 12'(p[6]) + 12'(p[8]) + (12'(p[7]) <<< 1)
           - 12'(p[0]) - 12'(p[2]) - (12'(p[1]) <<< 1);
        ax = gx[11] ? 11'(-gx) : 11'(gx);
        ay = gy[11] ? 11'(-gy) : 11'(gy);
        s_q[2-c] <= 17'((22'(ax) * 22'(ax) + 22'(ay) * 22'(ay)) > 22'd65280
                    ? 22'd65281 : 22'(ax) * 22'(ax) + 22'(ay) * 22'(ay));
        q_q[2-c] <= '0;
      end
    end else if (cmd_i.calc) begin
      bit_q <= bit_q >> 1;
      for (int c = 0; c < 3; c++) begin
        logic [8:0] t;
        t = q_q[c] | {1'b0, bit_q};
        if (18'(t) * 18'(t) <= 18'(s_q[c])) q_q[c] <= t;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (s_q[c] > 17'd65280) res[c] = 8'd255;
      else if (18'(s_q[c]) > 18'(q_q[c]) * 18'(q_q[c]) + 18'(q_q[c]))
        res[c] = 8'(q_q[c] + 9'd1);
      else res[c] = q_q[c][7:0];
    end
  end

  // output register frees the magnitude unit for the next request
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      edge_q <= {res[0], res[1], res[2]};
      frame_end_q <= last_q;
    end
  end

  assign sts_o.emits = emit_q;
  assign sts_o.done = (bit_q == 8'd0);
  assign edge_o = edge_q;
  assign last_o = frame_end_q;
endmodule

@@ rtl/core/sobel_edge_magnitude.sv @@
// Sobel edge magnitude, RGB, 3x3, zero border.
// A request is taken, the window shifts and the Sobel sums are registered;
// an item with a result then runs the bit-serial square root (8 steps) and
// is pushed out. No new item is taken before the last is done. No clearing
// pass; reset clears counters, window and config to 640x480 immediately.
`timescale 1ns / 1ps
module sobel_edge_magnitude #(
  parameter int MaxLine = sem_pkg::MAX_LINE
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // red_in, green_in, blue_in
  input  logic        s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // red_edge, green_edge, blue_edge
  output logic        m_axis_tlast   // frame_end
);
  sem_pkg::cmd_t cmd;
  sem_pkg::sts_t sts;
  logic [23:0] pix;
  assign pix = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};

  sem_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd)
  );

  logic [23:0] edges;
  sem_datapath #(.MaxLine(MaxLine)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .func_i(s_axis_tuser), .pix_i(pix), .cmd_i(cmd), .sts_o(sts),
    .edge_o(edges), .last_o(m_axis_tlast)
  );
  assign m_axis_tdata = {edges[7:0], edges[15:8], edges[23:16]};
endmodule

@@ rtl/core/sem_checker.sv @@
// Port checker for the Sobel edge magnitude block, bound to the top level.
// Depends on sobel_edge_magnitude_assert.svh.
`timescale 1ns / 1ps
`include "sobel_edge_magnitude_assert.svh"
module sem_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  `SEM_ASSERT_IMP(a_known, clk_i, rst_ni, m_axis_tvalid, !$isunknown(m_axis_tdata) && !$isunknown(m_axis_tlast))
  `SEM_ASSERT_NXT(a_take_blocks, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `SEM_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                  m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);

@@ dv/tb_sobel_edge_magnitude.sv @@
// Self-checking testbench for sobel_edge_magnitude: drives pixel and drain requests,
// predicts every edge result in a scoreboard class and compares each field.
// Depends on sem_pkg and the sobel_edge_magnitude RTL.
`timescale 1ns / 1ps
module tb_sobel_edge_magnitude;

  localparam int CycleLimit = 2000000;
  localparam int SettleCycles = 40;
  localparam int TargetItems = 1850;

  typedef struct packed {
    logic [23:0] edges;
    logic        last;
  } edge_result_t;

  class edge_scoreboard;
    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic [23:0] row_up[sem_pkg::MAX_LINE];
    logic [23:0] row_lo[sem_pkg::MAX_LINE];
    logic [23:0] win[9];
    int unsigned in_col, in_row, out_col, out_row, seen;
    edge_result_t pending[$];
    int errors;

    function new();
      width_reg = sem_pkg::WIDTH_RESET;
      height_reg = sem_pkg::HEIGHT_RESET;
      foreach (row_up[i]) begin
        row_up[i] = '0;
        row_lo[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0; seen = 0;
      errors = 0;
    endfunction

    function void set_cfg(logic [0:0] idx, logic [15:0] value);
      if (idx == sem_pkg::CFG_WIDTH) width_reg = value[10:0];
      else height_reg = value;
    endfunction

    function int unsigned eff_w();
      if (width_reg == 0) return 1;
      if (width_reg > sem_pkg::MAX_LINE) return sem_pkg::MAX_LINE;
      return width_reg;
    endfunction

    function int unsigned eff_h();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function bit frame_idle();
      return seen == 0 && in_col == 0 && in_row == 0 && out_col == 0 && out_row == 0;
    endfunction

    // rounded integer square root, clamped to 255
    function logic [7:0] magnitude(int unsigned s);
      int unsigned q, t;
      q = 0;
      if (s > 65280) return 8'd255;
      for (int b = 7; b >= 0; b--) begin
        t = q | (1 << b);
        if (t * t <= s) q = t;
      end
      if (s > q * q + q) q++;
      return q[7:0];
    endfunction

    function logic [7:0] channel(int sh, int orow, int ocol, int w, int h);
      int kx[9];
      int ky[9];
      int gx, gy, rr, cc, p;
      kx = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
      ky = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};
      gx = 0;
      gy = 0;
      for (int i = 0; i < 3; i++) begin
        rr = orow - 1 + i;
        for (int j = 0; j < 3; j++) begin
          cc = ocol - 1 + j;
          // mask taps outside the frame
          if (rr >= 0 && rr < h && cc >= 0 && cc < w) begin
            p = int'(win[i*3+j][sh+:8]);
            gx += p * kx[i*3+j];
            gy += p * ky[i*3+j];
          end
        end
      end
      if (gx < 0) gx = -gx;
      if (gy < 0) gy = -gy;
      return magnitude(gx * gx + gy * gy);
    endfunction

    function void note_input(logic func, logic [23:0] data);
      int unsigned w, h, col, idx;
      logic [23:0] v, up, lo;
      edge_result_t res;
      w = eff_w();
      h = eff_h();
      v = func ? 24'd0 : data;
      col = (in_col >= w) ? 0 : in_col;
      idx = col % sem_pkg::MAX_LINE;
      up = row_up[idx];
      lo = row_lo[idx];
      row_up[idx] = lo;
      row_lo[idx] = v;
      for (int k = 0; k < 3; k++) begin
        win[k*3] = win[k*3+1];
        win[k*3+1] = win[k*3+2];
      end
      win[2] = up;
      win[5] = lo;
      win[8] = v;
      in_col = col + 1;
      if (in_col >= w) begin
        in_col = 0;
        if (in_row < 16'hFFFF) in_row++;
      end
      if (seen < w + 1) begin
        seen++;
        return;
      end
      res.edges = {channel(16, out_row, out_col, w, h), channel(8, out_row, out_col, w, h),
                   channel(0, out_row, out_col, w, h)};
      res.last = 1'b0;
      if (out_col + 1 >= w) begin
        out_col = 0;
        if (out_row + 1 >= h) res.last = 1'b1;
        else out_row++;
      end else begin
        out_col++;
      end
      if (res.last) begin
        in_col = 0; in_row = 0; out_col = 0; out_row = 0; seen = 0;
      end
      pending.push_back(res);
    endfunction

    function void check_result(logic [23:0] data, logic last);
      edge_result_t want;
      if (pending.size() == 0) begin
        if (errors < 10) $display("unexpected result data=%h last=%b", data, last);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (want.edges !== data || want.last !== last) begin
        if (errors < 10)
          $display("mismatch: expected edges=%h last=%b, got edges=%h last=%b",
                   want.edges, want.last, data, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = sem_pkg::CFG_WIDTH;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // red_in, green_in, blue_in
  logic        s_axis_tuser = 1'b0;  // func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;  // red_edge, green_edge, blue_edge
  logic        m_axis_tlast;  // frame_end

  edge_scoreboard sb = new();
  bit idle_en = 1'b1;
  int hold_left = 0;
  int items_sent = 0;
  int cycles = 0;

  sobel_edge_magnitude DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stalls plus an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = !(idle_en && $urandom_range(0, 99) < 19);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
  end

  task automatic send_item(input logic func, input logic [23:0] data);
    if (idle_en && $urandom_range(0, 99) < 19) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = func;
    s_axis_tdata = data;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(func, data);
    items_sent++;
    @(negedge clk_i);
  endtask

  // drop valid and hold until every expected result is out, then let the block settle
  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [0:0] idx, input logic [15:0] value);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_cfg(idx, value);
  endtask

  // advance the window with drains until the frame closes; optionally slip pixels in
  task automatic flush_frame(input bit noisy);
    while (!sb.frame_idle())
      send_item(!(noisy && $urandom_range(0, 3) == 0), $urandom());
  endtask

  // pattern: 0 random, 1 all ones, 2 all zero, 3 checker
  task automatic send_pixels(input int n, input int pattern);
    logic [23:0] px;
    for (int i = 0; i < n; i++) begin
      case (pattern)
        1: px = 24'hFFFFFF;
        2: px = 24'h000000;
        3: px = (i % 2) ? 24'hFFFFFF : 24'h000000;
        default: px = $urandom();
      endcase
      send_item(1'b0, px);
    end
  endtask

  task automatic run_frame(input int w, input int h, input int pattern, input bit noisy);
    wait_idle();
    write_cfg(sem_pkg::CFG_WIDTH, 16'(w));
    write_cfg(sem_pkg::CFG_HEIGHT, 16'(h));
    send_pixels(w * h, pattern);
    flush_frame(noisy);
  endtask

  initial begin
    int w, h;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: saturated, flat and checkered frames, pixels in drain slots
    run_frame(3, 3, 1, 1'b0);
    run_frame(3, 3, 2, 1'b0);
    run_frame(4, 2, 3, 1'b1);
    // width and height of zero act as one
    run_frame(0, 0, 0, 1'b0);
    // tallest frame, cut short by resizing mid-frame
    wait_idle();
    write_cfg(sem_pkg::CFG_WIDTH, 16'd3);
    write_cfg(sem_pkg::CFG_HEIGHT, 16'hFFFF);
    send_pixels(12, 0);
    wait_idle();
    write_cfg(sem_pkg::CFG_HEIGHT, 16'd4);
    write_cfg(sem_pkg::CFG_WIDTH, 16'd2);
    flush_frame(1'b0);
    // widest register value acts as the full line: wrap the input column once, then shrink
    wait_idle();
    write_cfg(sem_pkg::CFG_WIDTH, 16'd2047);
    write_cfg(sem_pkg::CFG_HEIGHT, 16'd1);
    send_pixels(sem_pkg::MAX_LINE + 6, 0);
    wait_idle();
    write_cfg(sem_pkg::CFG_WIDTH, 16'd2);
    flush_frame(1'b0);

    // random frames, mostly small
    while (items_sent < TargetItems) begin
      idle_en = !(items_sent > 1250 && items_sent < 1450);
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      if ($urandom_range(0, 9) == 0) begin
        // broken sequence: random mix of pixels and drains, then close the frame
        wait_idle();
        write_cfg(sem_pkg::CFG_WIDTH, 16'(w));
        write_cfg(sem_pkg::CFG_HEIGHT, 16'(h));
        repeat ($urandom_range(1, 3 * w)) send_item($urandom_range(0, 1), $urandom());
        flush_frame(1'b1);
      end else if (hold_left == 0 && items_sent > 1500 && items_sent < 1700) begin
        // stall the result side so the block backs up into its input
        wait_idle();
        write_cfg(sem_pkg::CFG_WIDTH, 16'd8);
        write_cfg(sem_pkg::CFG_HEIGHT, 16'd6);
        hold_left = 400;
        send_pixels(48, 0);
        flush_frame(1'b0);
      end else begin
        run_frame(w, h, 0, $urandom_range(0, 4) == 0);
      end
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/sem_pkg.sv
rtl/core/sem_ctrl.sv
rtl/core/sem_datapath.sv
rtl/core/sobel_edge_magnitude.sv
rtl/core/sem_checker.sv
dv/tb_sobel_edge_magnitude.sv
